// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL. Both forms sample on clk and are
// disabled while rst_n is low, so the enclosing module must have those names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KLI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KLI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/kli_pkg.sv =====
`timescale 1ns / 1ps

package kli_pkg;

    localparam int POSE_W     = 31;
    localparam int CUR_W      = 32;
    localparam int STEPS_W    = 10;
    localparam int ACTION_W   = 2;
    localparam int NUM_COMP   = 4;
    localparam int COMP_W     = 2;
    localparam int DIV_CNT_W  = $clog2(CUR_W);

    localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd190;

    // Action codes of an input word.
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAVE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE = 2'd2;

    // Pose components.
    localparam logic [COMP_W-1:0] COMP_X       = 2'd0;
    localparam logic [COMP_W-1:0] COMP_Y       = 2'd1;
    localparam logic [COMP_W-1:0] COMP_Z       = 2'd2;
    localparam logic [COMP_W-1:0] COMP_HEADING = 2'd3;

    typedef struct packed {
        logic [POSE_W-1:0] x;
        logic [POSE_W-1:0] y;
        logic [POSE_W-1:0] z;
        logic [POSE_W-1:0] heading;
    } pose_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_DIV_GO,
        ST_DIV_WAIT
    } kli_state_t;

    function automatic logic [POSE_W-1:0] pose_field(pose_t p, logic [COMP_W-1:0] k);
        logic [POSE_W-1:0] f;
        case (k)
            COMP_X:       f = p.x;
            COMP_Y:       f = p.y;
            COMP_Z:       f = p.z;
            COMP_HEADING: f = p.heading;
            default:      f = p.x;
        endcase
        return f;
    endfunction

    function automatic logic [CUR_W-1:0] sext_pose(logic [POSE_W-1:0] v);
        return {v[POSE_W-1], v};
    endfunction

endpackage

// ===== design/kli_kf_mem.sv =====
`timescale 1ns / 1ps

// Keyframe store: one write port and one read port with registered read data.
module kli_kf_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  kli_pkg::pose_t      wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output kli_pkg::pose_t      rdata
);

    kli_pkg::pose_t mem [DEPTH];
    kli_pkg::pose_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/kli_div.sv =====
`timescale 1ns / 1ps

// Signed by unsigned restoring divider, one quotient bit per cycle.
// The quotient truncates toward zero; done pulses for one cycle when it is ready.
module kli_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [kli_pkg::CUR_W-1:0]        dividend,
    input  logic [kli_pkg::STEPS_W-1:0]      divisor,
    output logic                             done,
    output logic [kli_pkg::CUR_W-1:0]        quotient
);

    localparam int W  = kli_pkg::CUR_W;
    localparam int DW = kli_pkg::STEPS_W;
    localparam int CNTW = kli_pkg::DIV_CNT_W;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [W-1:0]    quo_reg, quo_next;
    logic            neg_reg, neg_next;
    logic [DW-1:0]   d_reg, d_next;

    logic [DW:0]     shifted;
    logic [DW:0]     trial;
    logic            fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, d_reg};
    assign fits    = shifted >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            neg_next  = dividend[W-1];
            quo_next  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + W'(1)) : quo_reg;

endmodule

// ===== design/keyframe_linear_interpolator_unit.sv =====
`timescale 1ns / 1ps

// Keyframe linear interpolator.
// An input word is taken at a rising edge where start is high and busy is low.
// action selects tick, save keyframe (from pose_x/y/z/heading) or toggle
// playback. Every word yields exactly one result word, presented for a single
// cycle with done high; the receiver cannot stall, so it must take it then.
// Saves, ordinary ticks, stop requests and unused codes need no division:
// done is high in the cycle after the accepting edge and busy never rises, so
// such words may arrive every cycle.
// A toggle that starts playback, and a tick that crosses into a new segment,
// read two keyframes from the store and run four divisions on one shared
// restoring divider that retires one quotient bit per cycle. The sequencer
// passes through ST_RD_A and ST_RD_B, then ST_DIV_GO and ST_DIV_WAIT for
// each component; busy stays high until done rises.
// steps_per_segment is written through cfg_we / cfg_wdata and is meant to be
// changed only while the block is idle. Reset stops playback, empties the
// store, clears the pose and increments and sets steps_per_segment to 190.
module keyframe_linear_interpolator_unit #(
    parameter int MAX_KEYFRAMES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic signed [30:0]            pose_x,
    input  logic signed [30:0]            pose_y,
    input  logic signed [30:0]            pose_z,
    input  logic signed [30:0]            pose_heading,
    input  logic                          cfg_we,
    input  logic [9:0]                    cfg_wdata,
    output logic                          done,
    output logic signed [31:0]            cur_x,
    output logic signed [31:0]            cur_y,
    output logic signed [31:0]            cur_z,
    output logic signed [31:0]            cur_heading,
    output logic                          is_playing,
    output logic [2:0]                    segment,
    output logic [3:0]                    stored_count,
    output logic                          save_refused
);

    localparam int AW  = $clog2(MAX_KEYFRAMES);
    localparam int FCW = $clog2(MAX_KEYFRAMES + 1);
    localparam int CW  = FCW + 1;
    localparam int NC  = kli_pkg::NUM_COMP;
    localparam int PW  = kli_pkg::CUR_W;
    localparam int SW  = kli_pkg::STEPS_W;

    // Control state.
    kli_pkg::kli_state_t state_reg, state_next;
    logic [SW-1:0]       steps_reg;
    logic [FCW-1:0]      fc_reg, fc_next;
    logic [AW-1:0]       seg_reg, seg_next;
    logic [SW-1:0]       tick_reg, tick_next;
    logic                playing_reg, playing_next;
    logic                load_reg, load_next;
    logic [kli_pkg::COMP_W-1:0] comp_reg, comp_next;
    logic                done_reg, done_next;
    logic                refused_reg, refused_next;

    // Pose and increments.
    logic [PW-1:0]       cur_reg [NC];
    logic [PW-1:0]       cur_next [NC];
    logic [PW-1:0]       step_reg [NC];
    logic [PW-1:0]       step_next [NC];

    // Keyframes of the segment being set up.
    kli_pkg::pose_t      a_reg, b_reg;

    // Store and divider hookup.
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    kli_pkg::pose_t      mem_wdata, mem_rdata;
    logic                div_start, div_done;
    logic [PW-1:0]       div_dividend, div_quotient;

    logic                accept;
    logic [SW-1:0]       eff_steps;
    logic                tick_end;
    logic [AW-1:0]       seg_inc;
    logic [CW-1:0]       seg_ext, fc_ext;
    logic                seg_last;
    logic                start_play;
    logic                needs_div;

    assign busy   = (state_reg != kli_pkg::ST_IDLE);
    assign accept = start && !busy;

    // A zero step count behaves as one.
    assign eff_steps  = (steps_reg == '0) ? SW'(1) : steps_reg;
    assign tick_end   = (tick_reg >= eff_steps);
    assign seg_inc    = seg_reg + AW'(1);
    assign seg_ext    = {{(CW - AW){1'b0}}, seg_reg};
    assign fc_ext     = {1'b0, fc_reg};
    // The next segment would start past the second-to-last keyframe.
    assign seg_last   = (seg_ext + CW'(3)) > fc_ext;
    assign start_play = !playing_reg && (fc_reg > FCW'(1));

    assign needs_div = ((action == kli_pkg::ACT_TICK) && playing_reg && tick_end && !seg_last)
                    || ((action == kli_pkg::ACT_TOGGLE) && start_play);

    assign mem_wdata.x       = pose_x;
    assign mem_wdata.y       = pose_y;
    assign mem_wdata.z       = pose_z;
    assign mem_wdata.heading = pose_heading;
    assign mem_waddr         = fc_reg[AW-1:0];

    // Difference of the selected component, both keyframes widened to 32 bits.
    assign div_dividend = kli_pkg::sext_pose(kli_pkg::pose_field(b_reg, comp_reg))
                        - kli_pkg::sext_pose(kli_pkg::pose_field(a_reg, comp_reg));

    kli_kf_mem #(
        .DEPTH (MAX_KEYFRAMES),
        .AW    (AW)
    ) u_kf_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    kli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_steps),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kli_pkg::ST_IDLE:
            begin
                if (accept && needs_div)
                begin
                    state_next = kli_pkg::ST_RD_A;
                end
            end
            kli_pkg::ST_RD_A:   state_next = kli_pkg::ST_RD_B;
            kli_pkg::ST_RD_B:   state_next = kli_pkg::ST_DIV_GO;
            kli_pkg::ST_DIV_GO: state_next = kli_pkg::ST_DIV_WAIT;
            kli_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (comp_reg == kli_pkg::COMP_HEADING) ? kli_pkg::ST_IDLE
                                                                     : kli_pkg::ST_DIV_GO;
                end
            end
            default:            state_next = kli_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: datapath and store controls.
    always_comb
    begin
        fc_next      = fc_reg;
        seg_next     = seg_reg;
        tick_next    = tick_reg;
        playing_next = playing_reg;
        load_next    = load_reg;
        comp_next    = comp_reg;
        done_next    = 1'b0;
        refused_next = refused_reg;
        for (int k = 0; k < NC; k++)
        begin
            cur_next[k]  = cur_reg[k];
            step_next[k] = step_reg[k];
        end
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = seg_inc;
        div_start = 1'b0;

        case (state_reg)
            kli_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    refused_next = 1'b0;
                    case (action)
                        kli_pkg::ACT_TICK:
                        begin
                            if (playing_reg && tick_end)
                            begin
                                if (seg_last)
                                begin
                                    seg_next     = '0;
                                    playing_next = 1'b0;
                                    done_next    = 1'b1;
                                end
                                else
                                begin
                                    // First keyframe of the new segment.
                                    seg_next  = seg_inc;
                                    tick_next = '0;
                                    load_next = 1'b0;
                                    mem_re    = 1'b1;
                                    mem_raddr = seg_inc;
                                end
                            end
                            else if (playing_reg)
                            begin
                                for (int k = 0; k < NC; k++)
                                begin
                                    cur_next[k] = cur_reg[k] + step_reg[k];
                                end
                                tick_next = tick_reg + SW'(1);
                                done_next = 1'b1;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        kli_pkg::ACT_SAVE:
                        begin
                            if (fc_reg < FCW'(MAX_KEYFRAMES))
                            begin
                                mem_we  = 1'b1;
                                fc_next = fc_reg + FCW'(1);
                            end
                            else
                            begin
                                refused_next = 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        kli_pkg::ACT_TOGGLE:
                        begin
                            if (start_play)
                            begin
                                seg_next     = '0;
                                tick_next    = '0;
                                playing_next = 1'b1;
                                load_next    = 1'b1;
                                mem_re       = 1'b1;
                                mem_raddr    = '0;
                            end
                            else
                            begin
                                playing_next = 1'b0;
                                done_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            kli_pkg::ST_RD_A:
            begin
                // Keyframe a is on the read port; fetch keyframe b next.
                if (load_reg)
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        cur_next[k] = kli_pkg::sext_pose(
                            kli_pkg::pose_field(mem_rdata, kli_pkg::COMP_W'(k)));
                    end
                end
                mem_re    = 1'b1;
                mem_raddr = seg_inc;
            end
            kli_pkg::ST_RD_B:
            begin
                comp_next = kli_pkg::COMP_X;
            end
            kli_pkg::ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            kli_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    step_next[comp_reg] = div_quotient;
                    if (comp_reg == kli_pkg::COMP_HEADING)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        comp_next = comp_reg + kli_pkg::COMP_W'(1);
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kli_pkg::ST_IDLE;
            fc_reg      <= '0;
            seg_reg     <= '0;
            tick_reg    <= '0;
            playing_reg <= 1'b0;
            load_reg    <= 1'b0;
            comp_reg    <= kli_pkg::COMP_X;
            done_reg    <= 1'b0;
            refused_reg <= 1'b0;
            for (int k = 0; k < NC; k++)
            begin
                cur_reg[k]  <= '0;
                step_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            fc_reg      <= fc_next;
            seg_reg     <= seg_next;
            tick_reg    <= tick_next;
            playing_reg <= playing_next;
            load_reg    <= load_next;
            comp_reg    <= comp_next;
            done_reg    <= done_next;
            refused_reg <= refused_next;
            for (int k = 0; k < NC; k++)
            begin
                cur_reg[k]  <= cur_next[k];
                step_reg[k] <= step_next[k];
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= kli_pkg::STEPS_RESET;
        end
        else if (cfg_we)
        begin
            steps_reg <= cfg_wdata;
        end
    end

    // Segment keyframes, taken from the registered read data in ST_RD_A and ST_RD_B.
    always_ff @(posedge clk)
    begin
        if (state_reg == kli_pkg::ST_RD_A)
        begin
            a_reg <= mem_rdata;
        end
        if (state_reg == kli_pkg::ST_RD_B)
        begin
            b_reg <= mem_rdata;
        end
    end

    // Result word. The state registers already hold the post-item values
    // during the strobe cycle, and no new word can land before it ends.
    logic [AW+2:0]  seg_wide;
    logic [FCW+3:0] fc_wide;

    assign seg_wide = {3'b000, seg_reg};
    assign fc_wide  = {4'b0000, fc_reg};

    assign done         = done_reg;
    assign cur_x        = cur_reg[kli_pkg::COMP_X];
    assign cur_y        = cur_reg[kli_pkg::COMP_Y];
    assign cur_z        = cur_reg[kli_pkg::COMP_Z];
    assign cur_heading  = cur_reg[kli_pkg::COMP_HEADING];
    assign is_playing   = playing_reg;
    assign segment      = seg_wide[2:0];
    assign stored_count = fc_wide[3:0];
    assign save_refused = refused_reg;

`include "assert_macros.svh"

    `KLI_ASSERT_IMP(a_no_strobe_in_flight, busy, !done_reg, "result strobe while a word is in flight")
    `KLI_ASSERT_IMP(a_store_bound, 1'b1, fc_reg <= FCW'(MAX_KEYFRAMES), "keyframe count beyond store depth")
    `KLI_ASSERT_IMP(a_segment_bound, playing_reg, (seg_ext + CW'(2)) <= fc_ext, "segment past last keyframe pair")
    `KLI_ASSERT_IMP(a_div_owner, div_done, state_reg == kli_pkg::ST_DIV_WAIT, "quotient returned while not waiting")
    `KLI_ASSERT_NXT(a_save_one_cycle, accept && (action == kli_pkg::ACT_SAVE), done_reg, "save did not finish in one cycle")

endmodule

// ===== tb/keyframe_linear_interpolator_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the keyframe interpolator.
// An initial block fills a queue of pending words and writes steps_per_segment
// between phases. A clocked driver presents the words on the start/busy
// handshake. At each accepting edge it runs the bench's own copy of the
// interpolator, and the result that copy predicts goes into a queue. A clocked
// monitor takes every done strobe and compares the result word, field by field,
// with the oldest prediction.
module keyframe_linear_interpolator_unit_tb;

    localparam int ACTION_W = kli_pkg::ACTION_W;
    localparam int POSE_W   = kli_pkg::POSE_W;
    localparam int CUR_W    = kli_pkg::CUR_W;
    localparam int STEPS_W  = kli_pkg::STEPS_W;
    localparam int NUM_COMP = kli_pkg::NUM_COMP;

    localparam int KF_SLOTS     = 8;
    localparam int WORD_TARGET  = 1850;   // least number of input words to send
    localparam int GAP_PCT      = 38;
    localparam int SETTLE_TICKS = 150;    // settle time after the final drain, in clocks

    // Action code 3 is not defined by the block and must change nothing.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [POSE_W-1:0] POSE_MAX = {1'b0, {(POSE_W-1){1'b1}}};
    localparam logic [POSE_W-1:0] POSE_MIN = {1'b1, {(POSE_W-1){1'b0}}};

    // Component k of a pose sits at index k, with COMP_X at index 0.
    typedef logic [NUM_COMP-1:0][POSE_W-1:0] pose_set_t;
    typedef logic [NUM_COMP-1:0][CUR_W-1:0]  cur_set_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        pose_set_t           pose;
    } interp_word_t;

    typedef struct packed {
        cur_set_t pose;
        logic     playing;
        logic [2:0] seg;
        logic [3:0] count;
        logic     refused;
    } interp_view_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [ACTION_W-1:0] action = kli_pkg::ACT_TICK;
    logic signed [POSE_W-1:0] pose_x = '0;
    logic signed [POSE_W-1:0] pose_y = '0;
    logic signed [POSE_W-1:0] pose_z = '0;
    logic signed [POSE_W-1:0] pose_heading = '0;
    logic cfg_we = 1'b0;
    logic [STEPS_W-1:0] cfg_wdata = '0;
    logic done;
    logic signed [CUR_W-1:0] cur_x;
    logic signed [CUR_W-1:0] cur_y;
    logic signed [CUR_W-1:0] cur_z;
    logic signed [CUR_W-1:0] cur_heading;
    logic is_playing;
    logic [2:0] segment;
    logic [3:0] stored_count;
    logic save_refused;

    keyframe_linear_interpolator_unit #(
        .MAX_KEYFRAMES(KF_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .pose_x(pose_x),
        .pose_y(pose_y),
        .pose_z(pose_z),
        .pose_heading(pose_heading),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .cur_x(cur_x),
        .cur_y(cur_y),
        .cur_z(cur_z),
        .cur_heading(cur_heading),
        .is_playing(is_playing),
        .segment(segment),
        .stored_count(stored_count),
        .save_refused(save_refused)
    );

    always #4 clk = ~clk;

    // Stimulus and scoreboard bookkeeping.
    interp_word_t pending_words[$];
    interp_view_t views_due[$];
    interp_word_t word_now;
    bit no_gaps = 1'b0;
    int words_queued = 0;
    int err_count = 0;
    string comp_name[NUM_COMP] = '{"cur_x", "cur_y", "cur_z", "cur_heading"};

    // The bench's copy of the interpolator state. Keyframe slots are only
    // read once they have been written, since playback never reaches past
    // the last stored keyframe.
    logic [STEPS_W-1:0] steps_cfg = kli_pkg::STEPS_RESET;
    pose_set_t kf_store [KF_SLOTS];
    cur_set_t pose_now = '0;
    cur_set_t incr_now = '0;
    int kf_count = 0;
    int seg_pos = 0;
    int tick_cnt = 0;
    bit playing = 1'b0;

    // A register value of zero behaves like one tick per segment.
    function automatic int eff_steps();
        return (steps_cfg == '0) ? 1 : int'(steps_cfg);
    endfunction

    // Per-tick increment from one keyframe component to the next. The
    // difference of two 31-bit values needs 32 bits; SystemVerilog signed
    // division truncates toward zero, which is what the block does.
    function automatic logic [CUR_W-1:0] seg_delta(logic [POSE_W-1:0] from_kf,
                                                   logic [POSE_W-1:0] to_kf);
        longint diff;
        longint quot;
        diff = longint'($signed(to_kf)) - longint'($signed(from_kf));
        quot = diff / longint'(eff_steps());
        return quot[CUR_W-1:0];
    endfunction

    function automatic void load_segment_incr();
        int k;
        for (k = 0; k < NUM_COMP; k++)
        begin
            incr_now[k] = seg_delta(kf_store[seg_pos][k], kf_store[seg_pos + 1][k]);
        end
    endfunction

    // Applies one accepted word to the bench's state and returns the result
    // word that the block must produce for it.
    function automatic interp_view_t interp_after_word(interp_word_t w);
        interp_view_t v;
        bit refused;
        int k;
        refused = 1'b0;
        case (w.action)
            kli_pkg::ACT_TICK:
            begin
                if (playing)
                begin
                    if (tick_cnt >= eff_steps())
                    begin
                        // Segment boundary: the pose holds still for this tick.
                        seg_pos++;
                        if (seg_pos > kf_count - 2)
                        begin
                            seg_pos = 0;
                            playing = 1'b0;
                        end
                        else
                        begin
                            tick_cnt = 0;
                            load_segment_incr();
                        end
                    end
                    else
                    begin
                        // 32-bit adders wrap; remainders are never snapped away.
                        for (k = 0; k < NUM_COMP; k++)
                        begin
                            pose_now[k] = pose_now[k] + incr_now[k];
                        end
                        tick_cnt = (tick_cnt + 1) & ((1 << STEPS_W) - 1);
                    end
                end
            end
            kli_pkg::ACT_SAVE:
            begin
                if (kf_count < KF_SLOTS)
                begin
                    kf_store[kf_count] = w.pose;
                    kf_count++;
                end
                else
                begin
                    refused = 1'b1;
                end
            end
            kli_pkg::ACT_TOGGLE:
            begin
                if (!playing && kf_count > 1)
                begin
                    for (k = 0; k < NUM_COMP; k++)
                    begin
                        pose_now[k] = {kf_store[0][k][POSE_W-1], kf_store[0][k]};
                    end
                    seg_pos = 0;
                    tick_cnt = 0;
                    load_segment_incr();
                    playing = 1'b1;
                end
                else
                begin
                    playing = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        v.pose = pose_now;
        v.playing = playing;
        v.seg = seg_pos[2:0];
        v.count = kf_count[3:0];
        v.refused = refused;
        return v;
    endfunction

    // Driver. A word counts as taken at an edge where start is high and busy
    // is low; the prediction is made right there, with the register value in
    // force at that moment. The next word, or a gap, is chosen whenever the
    // slot is free, so gaps land after short words and after divisions alike.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                views_due = {views_due, interp_after_word(word_now)};
            end
            if (!start || !busy)
            begin
                if (pending_words.size() > 0 && (no_gaps || $urandom_range(99) >= GAP_PCT))
                begin
                    word_now = pending_words.pop_front();
                    start <= 1'b1;
                    action <= word_now.action;
                    pose_x <= word_now.pose[kli_pkg::COMP_X];
                    pose_y <= word_now.pose[kli_pkg::COMP_Y];
                    pose_z <= word_now.pose[kli_pkg::COMP_Z];
                    pose_heading <= word_now.pose[kli_pkg::COMP_HEADING];
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. The result is valid only in the cycle that done marks, so it
    // is checked at the edge that ends that cycle.
    always @(posedge clk)
    begin : result_check
        interp_view_t want;
        cur_set_t got_pose;
        int k;
        if (rst_n && done)
        begin
            got_pose = {cur_heading, cur_z, cur_y, cur_x};
            if (views_due.size() == 0)
            begin
                err_count++;
                $display("%0t: result word with none outstanding, pose %0d %0d %0d %0d",
                         $time, cur_x, cur_y, cur_z, cur_heading);
            end
            else
            begin
                want = views_due.pop_front();
                for (k = 0; k < NUM_COMP; k++)
                begin
                    if (got_pose[k] !== want.pose[k])
                    begin
                        err_count++;
                        $display("%0t: %s expected %0d got %0d", $time, comp_name[k],
                                 $signed(want.pose[k]), $signed(got_pose[k]));
                    end
                end
                if (is_playing !== want.playing)
                begin
                    err_count++;
                    $display("%0t: is_playing expected %0b got %0b", $time,
                             want.playing, is_playing);
                end
                if (segment !== want.seg)
                begin
                    err_count++;
                    $display("%0t: segment expected %0d got %0d", $time, want.seg, segment);
                end
                if (stored_count !== want.count)
                begin
                    err_count++;
                    $display("%0t: stored_count expected %0d got %0d", $time,
                             want.count, stored_count);
                end
                if (save_refused !== want.refused)
                begin
                    err_count++;
                    $display("%0t: save_refused expected %0b got %0b", $time,
                             want.refused, save_refused);
                end
            end
        end
    end

    // Random pose, biased toward the range limits, zero and minus one.
    function automatic pose_set_t any_pose();
        pose_set_t p;
        int k;
        for (k = 0; k < NUM_COMP; k++)
        begin
            case ($urandom_range(9))
                0: p[k] = POSE_MAX;
                1: p[k] = POSE_MIN;
                2: p[k] = '0;
                3: p[k] = '1;
                default: p[k] = POSE_W'($urandom());
            endcase
        end
        return p;
    endfunction

    task automatic queue_word(logic [ACTION_W-1:0] act, pose_set_t p);
        interp_word_t w;
        w.action = act;
        w.pose = p;
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    // Returns once every queued word has been taken and answered. Every word
    // yields a result, so the block is idle at that point.
    task automatic drain();
        while (pending_words.size() != 0 || start || views_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_steps(logic [STEPS_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        steps_cfg = v;
    endtask

    initial
    begin : stimulus
        int phase;
        int len;
        int toggle_pct;
        int r;
        int i;
        logic [STEPS_W-1:0] steps;
        logic [ACTION_W-1:0] act;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset register value. Idle tick, stop
        // requests with an empty and a one-entry store, and the unused code.
        queue_word(kli_pkg::ACT_TICK, any_pose());
        queue_word(kli_pkg::ACT_TOGGLE, any_pose());
        queue_word(ACT_UNUSED, any_pose());
        queue_word(kli_pkg::ACT_SAVE, {NUM_COMP{POSE_MAX}});
        queue_word(kli_pkg::ACT_TOGGLE, any_pose());
        queue_word(kli_pkg::ACT_SAVE, {NUM_COMP{POSE_MIN}});
        // Start between the two extreme keyframes, then save during playback.
        queue_word(kli_pkg::ACT_TOGGLE, any_pose());
        queue_word(kli_pkg::ACT_TICK, any_pose());
        queue_word(kli_pkg::ACT_TICK, any_pose());
        queue_word(kli_pkg::ACT_SAVE, any_pose());
        queue_word(kli_pkg::ACT_TOGGLE, any_pose());

        // One tick per segment: the full swing lands in a single step, and
        // the run ends on its own after the last segment.
        write_steps(10'd1);
        queue_word(kli_pkg::ACT_TOGGLE, any_pose());
        for (i = 0; i < 5; i++)
        begin
            queue_word(kli_pkg::ACT_TICK, any_pose());
        end

        // Zero steps, which must behave like one. The store fills up while
        // playing, and one more save is refused.
        write_steps(10'd0);
        queue_word(kli_pkg::ACT_SAVE, any_pose());
        queue_word(kli_pkg::ACT_SAVE, any_pose());
        queue_word(kli_pkg::ACT_TOGGLE, any_pose());
        queue_word(kli_pkg::ACT_TICK, any_pose());
        queue_word(kli_pkg::ACT_TICK, any_pose());
        for (i = 0; i < 3; i++)
        begin
            queue_word(kli_pkg::ACT_SAVE, any_pose());
        end
        queue_word(kli_pkg::ACT_SAVE, any_pose());
        queue_word(ACT_UNUSED, any_pose());
        queue_word(kli_pkg::ACT_TICK, any_pose());

        // Random part. Each phase picks a register value, mostly small so that
        // playback crosses many segments; the largest value sometimes follows
        // a small one in mid-segment, which drives the pose adders to wrap.
        // Most words are ticks so that playback runs deep.
        phase = 0;
        while (words_queued < WORD_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 35)
                steps = STEPS_W'($urandom_range(3, 1));
            else if (r < 55)
                steps = STEPS_W'($urandom_range(12, 4));
            else if (r < 65)
                steps = '0;
            else if (r < 75)
                steps = '1;
            else
                steps = STEPS_W'($urandom_range(1023));
            write_steps(steps);

            // A few phases in the middle run without any gaps.
            no_gaps = (phase >= 3 && phase <= 5);
            toggle_pct = ($urandom_range(1) == 1) ? 2 : 8;
            len = $urandom_range(120, 40);
            for (i = 0; i < len; i++)
            begin
                r = $urandom_range(99);
                if (r < toggle_pct)
                    act = kli_pkg::ACT_TOGGLE;
                else if (r < toggle_pct + 4)
                    act = kli_pkg::ACT_SAVE;
                else if (r < toggle_pct + 6)
                    act = ACT_UNUSED;
                else
                    act = kli_pkg::ACT_TICK;
                queue_word(act, any_pose());
            end
            drain();
            phase++;
        end

        no_gaps = 1'b0;
        drain();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (err_count == 0)
        begin
            $display("** keyframe_linear_interpolator_unit: PASSED **");
        end
        else
        begin
            $display("** keyframe_linear_interpolator_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("** keyframe_linear_interpolator_unit: FAILED **");
        $finish;
    end

endmodule

// ===== keyframe_linear_interpolator_unit.f =====
+incdir+design
design/kli_pkg.sv
design/kli_kf_mem.sv
design/kli_div.sv
design/keyframe_linear_interpolator_unit.sv
tb/keyframe_linear_interpolator_unit_tb.sv
